// ===== sv/tps_pkg.sv =====
`default_nettype none

package tps_pkg;

    // Field and state widths
    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 10;
    localparam int DECAY_W     = 17;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_W       = 32;

    // Delay line
    localparam int DELAY_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int TAP_W       = LEN_W + 1;
    localparam int COUNT_W     = 11;

    // Datapath
    localparam int DIFF_W      = SAMPLE_W + 3;
    localparam int PP_W        = 40;
    localparam int ACC_W       = 64;
    localparam int MUL_B_W     = DECAY_W + 1;
    localparam int MUL_W       = DIFF_W + MUL_B_W;
    localparam int DIV_W       = DECAY_W + LEN_W;
    localparam int FRAC_W      = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 2'd3;

    // Reset values of the registers
    localparam logic [LEN_W-1:0]    RISE_RST     = 10'd10;
    localparam logic [LEN_W-1:0]    GAP_RST      = 10'd20;
    localparam logic [DECAY_W-1:0]  DECAY_RST    = 17'd40;
    localparam logic [SAMPLE_W-1:0] BASELINE_RST = 16'd0;

    // Write side of the delay memory
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } tps_wr_t;

endpackage

`default_nettype wire

// ===== sv/tps_delay_mem.sv =====
`default_nettype none

module tps_delay_mem (
    input  wire logic                          clk,
    input  wire tps_pkg::tps_wr_t              wr,
    input  wire logic [tps_pkg::ADDR_W-1:0]    raddr,
    output logic      [tps_pkg::SAMPLE_W-1:0]  rdata
);
    import tps_pkg::*;

    logic [SAMPLE_W-1:0] store_reg [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.addr] <= wr.data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/trapezoidal_pulse_shaper.sv =====
`default_nettype none

// Channel     Dir  Beat fields (lowest bit first)
// ----------  ---  -------------------------------------------------------
// s_*         in   tdata: sample[15:0]; tuser: start_of_record
// m_*         out  tdata: filtered_value[31:0] (Q24.8); tuser: divide_error
// cfg_*       in   index 0 rise_length, 1 gap_length, 2 decay_constant, 3 baseline
//
// For each sample the block steps from the accepting idle state through nine
// sequencer steps, 32 restoring divide iterations on the shared 64-bit adder
// (one quotient bit a cycle) and a final step that loads the output register;
// s_tready stays low until the block is back in idle. A zero divisor or an
// overflowing quotient skips the divide loop.
// rst_n clears the sequencer, accumulators, sample count and write pointer; the
// delay memory is not cleared. A result held by a stalled m_tready blocks only
// the final load step of the following sample.

module trapezoidal_pulse_shaper (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input sample stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tps_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  wire logic                          s_tuser,   // [0] start_of_record
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [tps_pkg::OUT_W-1:0]     m_tdata,   // [31:0] filtered_value
    output logic                               m_tuser,   // [0] divide_error
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tps_pkg::CFG_W-1:0]     cfg_data
);
    import tps_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TAPK   = 4'd1;
    localparam logic [3:0] S_TAPL   = 4'd2;
    localparam logic [3:0] S_TAPKL  = 4'd3;
    localparam logic [3:0] S_TAPSUM = 4'd4;
    localparam logic [3:0] S_PP     = 4'd5;
    localparam logic [3:0] S_ACC1   = 4'd6;
    localparam logic [3:0] S_ACC2   = 4'd7;
    localparam logic [3:0] S_ABS    = 4'd8;
    localparam logic [3:0] S_CHK    = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Where a tap value comes from
    localparam logic [1:0] TAP_CUR  = 2'd0;
    localparam logic [1:0] TAP_BASE = 2'd1;
    localparam logic [1:0] TAP_MEM  = 2'd2;

    localparam int CNT_W = $clog2(OUT_W);

    // Configuration registers
    logic [LEN_W-1:0]    rise_reg;
    logic [LEN_W-1:0]    gap_reg;
    logic [DECAY_W-1:0]  decay_reg;
    logic [SAMPLE_W-1:0] baseline_reg;

    // Control state
    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0]   wr_ptr_reg;
    logic [PP_W-1:0]     pp_reg;
    logic [ACC_W-1:0]    s_reg;
    logic                out_valid_reg;

    // Per-sample payload
    logic [SAMPLE_W-1:0] x_reg;
    logic [1:0]          tap_sel_reg;
    logic [DIFF_W-1:0]   d_reg;
    logic [MUL_W-1:0]    prod_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [ACC_W-1:0]    mag_reg;
    logic                neg_reg;
    logic                ovf_reg;
    logic                err_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [OUT_W-1:0]    num_reg;
    logic [OUT_W-1:0]    quot_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic                out_err_reg;

    // Shared datapath
    logic [ACC_W-1:0]    alu_a;
    logic [ACC_W-1:0]    alu_b;
    logic                alu_sub;
    logic [ACC_W:0]      alu_sum;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_W-1:0]   mul_p;

    logic                m_neg;
    logic [MUL_B_W-1:0]  abs_m;
    logic [TAP_W-1:0]    issue_delay;
    logic [1:0]          issue_sel;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] tap_val;
    logic [DIV_W:0]      div_trial;
    logic [OUT_W-1:0]    result;
    logic                accept;
    logic                out_load;
    tps_wr_t             mem_wr;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_neg    = decay_reg[DECAY_W-1];
    assign abs_m    = m_neg ? (~{1'b1, decay_reg} + MUL_B_W'(1)) : {1'b0, decay_reg};
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg     <= RISE_RST;
            gap_reg      <= GAP_RST;
            decay_reg    <= DECAY_RST;
            baseline_reg <= BASELINE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RISE:     rise_reg     <= cfg_data[LEN_W-1:0];
                REG_GAP:      gap_reg      <= cfg_data[LEN_W-1:0];
                REG_DECAY:    decay_reg    <= cfg_data[DECAY_W-1:0];
                REG_BASELINE: baseline_reg <= cfg_data[SAMPLE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Tap issue: pick the delay for this step and decide where its value comes from.
    // Zero delay is the current sample; a delay past the store or past the samples
    // seen in this record reads the baseline.
    always_comb
    begin
        case (state_reg)
            S_TAPK:  issue_delay = {1'b0, rise_reg};
            S_TAPL:  issue_delay = {1'b0, gap_reg};
            default: issue_delay = {1'b0, rise_reg} + {1'b0, gap_reg};
        endcase
        if (issue_delay == '0)
        begin
            issue_sel = TAP_CUR;
        end
        else if (issue_delay > TAP_W'(DELAY_DEPTH) || issue_delay > count_reg)
        begin
            issue_sel = TAP_BASE;
        end
        else
        begin
            issue_sel = TAP_MEM;
        end
        rd_addr = wr_ptr_reg - issue_delay[ADDR_W-1:0];
    end

    // Tap value of the read issued in the cycle before
    always_comb
    begin
        case (tap_sel_reg)
            TAP_CUR:  tap_val = x_reg;
            TAP_BASE: tap_val = baseline_reg;
            default:  tap_val = rd_data;
        endcase
    end

    assign mem_wr.en   = (state_reg == S_TAPSUM);
    assign mem_wr.addr = wr_ptr_reg;
    assign mem_wr.data = x_reg;

    tps_delay_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Shared multiplier: d*M for the decay term, then |M|*k for the divisor
    always_comb
    begin
        if (state_reg == S_ACC1)
        begin
            mul_a = $signed({{(DIFF_W-LEN_W){1'b0}}, rise_reg});
            mul_b = $signed(abs_m);
        end
        else
        begin
            mul_a = $signed(d_reg);
            mul_b = $signed({decay_reg[DECAY_W-1], decay_reg});
        end
        mul_p = mul_a * mul_b;
    end

    // Shared 64-bit adder; on subtract the carry out means a >= b
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_TAPL, S_TAPKL, S_TAPSUM:
            begin
                alu_a   = {{(ACC_W-DIFF_W){d_reg[DIFF_W-1]}}, d_reg};
                alu_b   = {{(ACC_W-SAMPLE_W){tap_val[SAMPLE_W-1]}}, tap_val};
                alu_sub = (state_reg != S_TAPSUM);
            end
            S_PP:
            begin
                alu_a = {{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg};
                alu_b = {{(ACC_W-DIFF_W){d_reg[DIFF_W-1]}}, d_reg};
            end
            S_ACC1:
            begin
                alu_a = s_reg;
                alu_b = m_neg ? {{(ACC_W-DIFF_W){d_reg[DIFF_W-1]}}, d_reg}
                              : {{(ACC_W-MUL_W){prod_reg[MUL_W-1]}}, prod_reg};
            end
            S_ACC2:
            begin
                alu_a = s_reg;
                alu_b = {{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg};
            end
            S_ABS:
            begin
                alu_b   = s_reg;
                alu_sub = 1'b1;
            end
            S_CHK:
            begin
                alu_a   = {{(OUT_W-FRAC_W){1'b0}}, mag_reg[ACC_W-1:OUT_W-FRAC_W]};
                alu_b   = {{(ACC_W-DIV_W){1'b0}}, div_reg};
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {{(ACC_W-DIV_W-1){1'b0}}, div_trial};
                alu_b   = {{(ACC_W-DIV_W){1'b0}}, div_reg};
                alu_sub = 1'b1;
            end
            default: ;
        endcase
        alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {ACC_W{alu_sub}}} + {{ACC_W{1'b0}}, alu_sub};
    end

    assign div_trial = {rem_reg, num_reg[OUT_W-1]};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_TAPK;
            S_TAPK:   state_next = S_TAPL;
            S_TAPL:   state_next = S_TAPKL;
            S_TAPKL:  state_next = S_TAPSUM;
            S_TAPSUM: state_next = S_PP;
            S_PP:     state_next = S_ACC1;
            S_ACC1:   state_next = S_ACC2;
            S_ACC2:   state_next = S_ABS;
            S_ABS:    state_next = S_CHK;
            S_CHK:
            begin
                if (div_reg == '0 || alu_sum[ACC_W])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:    if (cnt_reg == '0) state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer, record count, write pointer, accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            pp_reg     <= '0;
            s_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    // clear the record before its first sample is processed
                    if (accept && s_tuser)
                    begin
                        count_reg <= '0;
                        pp_reg    <= '0;
                        s_reg     <= '0;
                    end
                end
                S_TAPSUM:
                begin
                    wr_ptr_reg <= wr_ptr_reg + ADDR_W'(1);
                    if (count_reg != '1)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
                S_PP:   pp_reg <= alu_sum[PP_W-1:0];
                S_ACC1: s_reg  <= alu_sum[ACC_W-1:0];
                S_ACC2: if (!m_neg) s_reg <= alu_sum[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-sample datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg <= s_tdata;
                d_reg <= {{(DIFF_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
            end
            S_TAPK:
            begin
                tap_sel_reg <= issue_sel;
            end
            S_TAPL, S_TAPKL:
            begin
                tap_sel_reg <= issue_sel;
                d_reg       <= alu_sum[DIFF_W-1:0];
            end
            S_TAPSUM:
            begin
                d_reg <= alu_sum[DIFF_W-1:0];
            end
            S_PP:
            begin
                prod_reg <= mul_p;
            end
            S_ACC1:
            begin
                div_reg <= mul_p[DIV_W-1:0];
            end
            S_ABS:
            begin
                neg_reg <= s_reg[ACC_W-1];
                mag_reg <= s_reg[ACC_W-1] ? alu_sum[ACC_W-1:0] : s_reg;
            end
            S_CHK:
            begin
                // the quotient overflows 32 bits when mag >> 24 reaches the divisor
                err_reg  <= (div_reg == '0);
                ovf_reg  <= alu_sum[ACC_W];
                rem_reg  <= mag_reg[OUT_W-FRAC_W+DIV_W-1:OUT_W-FRAC_W];
                num_reg  <= {mag_reg[OUT_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
                quot_reg <= '0;
                cnt_reg  <= CNT_W'(OUT_W - 1);
            end
            S_DIV:
            begin
                // one restoring step: subtract when the trial remainder covers the divisor
                rem_reg  <= alu_sum[ACC_W] ? alu_sum[DIV_W-1:0] : div_trial[DIV_W-1:0];
                quot_reg <= {quot_reg[OUT_W-2:0], alu_sum[ACC_W]};
                num_reg  <= {num_reg[OUT_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Sign, saturation and the zero-divisor case
    always_comb
    begin
        if (err_reg)
        begin
            result = '0;
        end
        else if (ovf_reg)
        begin
            result = neg_reg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else if (neg_reg)
        begin
            if (quot_reg[OUT_W-1] && (quot_reg[OUT_W-2:0] != '0))
            begin
                result = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                result = ~quot_reg + OUT_W'(1);
            end
        end
        else
        begin
            result = quot_reg[OUT_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : quot_reg;
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result;
            out_err_reg  <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // The divide loop only runs with a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < div_reg))
        else $error("divide remainder not below divisor");

    // A sample is taken only once per pass through the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while sequencer busy");

    // A new output beat only comes from the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("output loaded outside final step");

    // A zero divisor always reports a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("divide error with nonzero value");

endmodule

`default_nettype wire

// ===== test/tps_shape_checker.sv =====
`timescale 1ns / 100ps

module tps_shape_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [tps_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  wire logic                          s_tuser,   // [0] start_of_record
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [tps_pkg::OUT_W-1:0]     m_tdata,   // [31:0] filtered_value
    input  wire logic                          m_tuser,   // [0] divide_error
    input  wire logic                          cfg_we,
    input  wire logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tps_pkg::CFG_W-1:0]     cfg_data,
    output int unsigned                        shapes_seen,
    output int unsigned                        mismatch_count
);

    import tps_pkg::*;

    localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
    localparam int unsigned PRINT_CAP  = 40;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             div_err;
    } shape_t;

    shape_t pending_shapes[$];

    // Shaper state as the block keeps it
    logic signed [SAMPLE_W-1:0] sample_hist [DELAY_DEPTH];
    logic        [ADDR_W-1:0]   hist_ptr;
    int unsigned                record_len;
    logic signed [PP_W-1:0]     pulse_sum;
    logic        [ACC_W-1:0]    shape_sum;

    // Register copies
    logic        [LEN_W-1:0]    rise;
    logic        [LEN_W-1:0]    gap;
    logic signed [DECAY_W-1:0]  decay;
    logic signed [SAMPLE_W-1:0] base_level;

    int unsigned fail_tally;
    int unsigned seen_tally;

    task automatic report_mismatch(input string msg);
        fail_tally++;
        if (fail_tally <= PRINT_CAP)
            $display("[check] %0t ns: %s", $time, msg);
    endtask

    // Sample dly positions back in the current record, baseline before it or past the store
    function automatic longint delayed_sample(input int unsigned dly, input longint cur);
        logic [ADDR_W-1:0] idx;
        if (dly == 0)
            return cur;
        if (dly > DELAY_DEPTH || dly > record_len)
            return longint'(base_level);
        idx = hist_ptr - ADDR_W'(dly);
        return longint'(sample_hist[idx]);
    endfunction

    task automatic shape_sample(input logic [SAMPLE_W-1:0] raw, input logic first);
        longint            x;
        longint            diff;
        longint            span;
        logic [ACC_W-1:0]  divisor;
        logic [ACC_W-1:0]  mag;
        logic [ACC_W-1:0]  quo;
        logic [ACC_W-1:0]  rem;
        logic [ACC_W-1:0]  q88;
        shape_t            want;
        x = longint'($signed(raw));
        if (first)
        begin
            record_len = 0;
            pulse_sum  = '0;
            shape_sum  = '0;
        end
        diff = x - delayed_sample(32'(rise), x) - delayed_sample(32'(gap), x)
                 + delayed_sample(32'(rise) + 32'(gap), x);
        pulse_sum = pulse_sum + PP_W'(diff);
        if (!decay[DECAY_W-1])
            shape_sum = shape_sum + ACC_W'(longint'(pulse_sum))
                                  + ACC_W'(diff * longint'(decay));
        else
            shape_sum = shape_sum + ACC_W'(diff);

        sample_hist[hist_ptr] = raw;
        hist_ptr = hist_ptr + ADDR_W'(1);
        if (record_len < COUNT_MAX)
            record_len++;

        span    = decay[DECAY_W-1] ? -longint'(decay) : longint'(decay);
        divisor = ACC_W'(span) * ACC_W'(rise);
        if (divisor == '0)
        begin
            want.value   = '0;
            want.div_err = 1'b1;
        end
        else
        begin
            mag = shape_sum[ACC_W-1] ? -shape_sum : shape_sum;
            quo = mag / divisor;
            rem = mag % divisor;
            if (quo >= (64'd1 << (OUT_W - FRAC_W)))
                q88 = 64'd1 << OUT_W;
            else
                q88 = (quo << FRAC_W) + ((rem << FRAC_W) / divisor);
            if (shape_sum[ACC_W-1])
            begin
                if (q88 > (64'd1 << (OUT_W - 1)))
                    q88 = 64'd1 << (OUT_W - 1);
                want.value = OUT_W'(-q88);
            end
            else
            begin
                if (q88 > ((64'd1 << (OUT_W - 1)) - 1))
                    q88 = (64'd1 << (OUT_W - 1)) - 1;
                want.value = OUT_W'(q88);
            end
            want.div_err = 1'b0;
        end
        pending_shapes.push_back(want);
    endtask

    task automatic check_shape(input logic [OUT_W-1:0] got_value, input logic got_err);
        shape_t want;
        seen_tally++;
        if (pending_shapes.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with no sample pending", seen_tally));
            return;
        end
        want = pending_shapes.pop_front();
        if (got_value !== want.value)
            report_mismatch($sformatf("result %0d filtered_value %0d, want %0d",
                                      seen_tally, $signed(got_value), $signed(want.value)));
        if (got_err !== want.div_err)
            report_mismatch($sformatf("result %0d divide_error %0b, want %0b",
                                      seen_tally, got_err, want.div_err));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise       = RISE_RST;
            gap        = GAP_RST;
            decay      = DECAY_RST;
            base_level = BASELINE_RST;
            hist_ptr   = '0;
            record_len = 0;
            pulse_sum  = '0;
            shape_sum  = '0;
            fail_tally = 0;
            seen_tally = 0;
            pending_shapes.delete();
            shapes_seen    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RISE:     rise       = cfg_data[LEN_W-1:0];
                    REG_GAP:      gap        = cfg_data[LEN_W-1:0];
                    REG_DECAY:    decay      = cfg_data[DECAY_W-1:0];
                    REG_BASELINE: base_level = cfg_data[SAMPLE_W-1:0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                shape_sample(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_shape(m_tdata, m_tuser);
            shapes_seen    <= seen_tally;
            mismatch_count <= fail_tally;
        end
    end

endmodule

// ===== test/tb_trapezoidal_pulse_shaper.sv =====
`timescale 1ns / 100ps

module tb_trapezoidal_pulse_shaper;

    import tps_pkg::*;

    // Far above the slowest legal run: ~1300 samples plus idle stretches on
    // each side.
    localparam int unsigned RUN_LIMIT = 1_000_000;
    // Settling time after the last result
    localparam int unsigned TAIL_CYCLES = 64;

    logic                 clk = 1'b0;
    logic                 rst_n;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata  = '0;      // [15:0] sample
    logic                 s_tuser  = 1'b0;    // [0] start_of_record

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;            // [31:0] filtered_value
    logic                 m_tuser;            // [0] divide_error

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_RISE;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int unsigned shapes_seen;
    int unsigned mismatch_count;
    int unsigned samples_sent   = 0;
    int unsigned settings_count = 0;
    int unsigned cycle_count    = 0;

    // Calm stretches: while set, that side never idles
    bit calm_tx = 1'b0;
    bit calm_rx = 1'b0;

    always #4 clk = ~clk;

    trapezoidal_pulse_shaper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tps_shape_checker shape_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .shapes_seen    (shapes_seen),
        .mismatch_count (mismatch_count)
    );

    // Watchdog: a hung handshake or a missing result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[trapezoidal_pulse_shaper] ERROR");
            $finish;
        end
    end

    // Offer one sample beat, idle a random number of cycles first, and hold
    // until the block takes it. Valid stays high into the next call so that
    // back-to-back beats never drop it within a step.
    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic first);
        int unsigned hold;
        if ($urandom_range(0, 99) < 3)
            calm_tx = !calm_tx;
        hold = calm_tx ? 0 : $urandom_range(0, 10);
        if (hold != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        samples_sent++;
    endtask

    // Drop valid and hold off until every accepted sample has its result;
    // the block is idle after that and may take register writes.
    task automatic wait_for_shapes();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (shapes_seen < samples_sent);
    endtask

    // Write all four registers back to back; we stays high across the burst
    task automatic load_shaper(input int unsigned rise_v, input int unsigned gap_v,
                               input int decay_v, input int base_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RISE;
        cfg_data  <= CFG_W'(rise_v);
        @(posedge clk);
        cfg_index <= REG_GAP;
        cfg_data  <= CFG_W'(gap_v);
        @(posedge clk);
        cfg_index <= REG_DECAY;
        cfg_data  <= CFG_W'(decay_v);
        @(posedge clk);
        cfg_index <= REG_BASELINE;
        cfg_data  <= CFG_W'(base_v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_count++;
    endtask

    // Records of random length: mostly a wandering level with pulse steps,
    // mixed with full-range noise and rail values. A few records carry no
    // start flag and a few flags land mid-record.
    task automatic run_records(input int unsigned items, input int unsigned max_len);
        int unsigned          left;
        int unsigned          len;
        int unsigned          pick;
        logic [SAMPLE_W-1:0]  level;
        logic [SAMPLE_W-1:0]  value;
        logic                 first;
        left = items;
        while (left > 0)
        begin
            len = $urandom_range(1, max_len);
            if (len > left)
                len = left;
            level = SAMPLE_W'($urandom);
            for (int unsigned i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    level = level + SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
                    value = level;
                end
                else if (pick < 65)
                begin
                    level = SAMPLE_W'($urandom);
                    value = level;
                end
                else if (pick < 85)
                    value = SAMPLE_W'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       value = 16'h7FFF;
                        1:       value = 16'h8000;
                        2:       value = 16'h0000;
                        default: value = 16'hFFFF;
                    endcase
                end
                first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                push_sample(value, first);
            end
            left -= len;
        end
    endtask

    // One record near a rail with a little ripple toward zero
    task automatic run_plateau(input int unsigned len, input logic [SAMPLE_W-1:0] top_v);
        logic [SAMPLE_W-1:0] ripple;
        for (int unsigned i = 0; i < len; i++)
        begin
            ripple = SAMPLE_W'($urandom_range(0, 7));
            push_sample(top_v[SAMPLE_W-1] ? top_v + ripple : top_v - ripple, i == 0);
        end
    endtask

    task automatic shaper_phase(input int unsigned rise_v, input int unsigned gap_v,
                                input int decay_v, input int base_v,
                                input int unsigned items, input int unsigned max_len);
        load_shaper(rise_v, gap_v, decay_v, base_v);
        run_records(items, max_len);
        wait_for_shapes();
    endtask

    // Result side: stall a random number of cycles per beat, with calm
    // stretches where ready stays high. Ready is lowered only when a stall
    // is drawn, so it never toggles twice in one step.
    initial
    begin
        int unsigned stall;
        forever
        begin
            if ($urandom_range(0, 99) < 3)
                calm_rx = !calm_rx;
            stall = calm_rx ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        int unsigned rise_v;
        int unsigned gap_v;
        int          decay_v;
        int          base_v;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings (rise 10, gap 20, decay 40, baseline 0).
        // The first record runs from reset without a start flag, then starts
        // land mid-stream and back to back; samples hit both rails and
        // alternating bit patterns.
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h1234, 1'b0);
        push_sample(16'hFEDC, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h0000, 1'b1);
        wait_for_shapes();

        // Decay constant zero: divisor zero on every beat, no gap tap
        shaper_phase(1, 0, 0, 0, 20, 12);

        // Widest window: taps reach 1024 back once the record is long
        // enough, and the plateau drives the quotient into positive clamp.
        load_shaper(512, 512, 1, -32768);
        run_plateau(1028, 16'h7FFF);
        wait_for_shapes();

        // Short rise, long gap: plateau below baseline clamps negative
        load_shaper(1, 512, 1, 32767);
        run_plateau(60, 16'h8000);
        wait_for_shapes();

        // Step mode and decay extremes, gap both below and above rise
        shaper_phase(7, 3, -1, -32768, 20, 20);
        shaper_phase(3, 9, -65535, 32767, 20, 20);
        shaper_phase(1, 1, 65535, -1, 20, 20);
        shaper_phase(512, 0, -65535, 0, 15, 15);
        shaper_phase(10, 20, 40, 0, 40, 40);

        // Random settings, mostly short windows so records fill them
        repeat (6)
        begin
            rise_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 6);
            gap_v   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 512) : $urandom_range(0, 6);
            decay_v = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 200)) - 100
                                                  : int'($urandom_range(0, 131070)) - 65535;
            base_v  = int'($urandom_range(0, 65535)) - 32768;
            shaper_phase(rise_v, gap_v, decay_v, base_v, 10, 10);
        end

        wait_for_shapes();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Shaped %0d samples over %0d register settings, step and decay mode,",
                 samples_sent, settings_count + 1);
        $display("zero divisor, clamping of both signs and taps out to the full store depth.");
        if (mismatch_count == 0)
            $display("[trapezoidal_pulse_shaper] OK");
        else
            $display("[trapezoidal_pulse_shaper] ERROR");
        $finish;
    end

endmodule
